// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active (active-low reset).
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Implication form: when cond holds, expr holds on the next clock.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, expr, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, (cond) |=> (expr), msg)

`endif

// ----- rtl/core/sadm_pkg.sv -----
// ----------------------------------------------------------------------------
// sadm_pkg
// Shared types and constants of the shift-and delta matcher.
// ----------------------------------------------------------------------------
package sadm_pkg;

    localparam int SYM_FIELD_W = 16;
    localparam int IDX_FIELD_W = 6;
    localparam int LEN_FIELD_W = 7;
    localparam int DELTA_W     = 16;
    localparam int POS_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_TEXT = 1'b1
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELTA  = 2'd0,
        CFG_LENGTH = 2'd1,
        CFG_RSVD2  = 2'd2,
        CFG_RSVD3  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        req_t                   req_type;
        logic [IDX_FIELD_W-1:0] pattern_index;
        logic [SYM_FIELD_W-1:0] symbol_value;
    } item_t;

    typedef struct packed {
        logic             match_found;
        logic [POS_W-1:0] start_position;
    } result_t;

endpackage

// ----- rtl/core/sadm_pattern_store.sv -----
// ----------------------------------------------------------------------------
// sadm_pattern_store
// Pattern symbol registers, one delta comparator per pattern position.
// ----------------------------------------------------------------------------
module sadm_pattern_store #(
    parameter int MAX_PATTERN = 64,
    parameter int SYMBOL_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            load_en,
    input  sadm_pkg::item_t                 item,
    input  logic [sadm_pkg::DELTA_W-1:0]    delta,
    output logic [MAX_PATTERN-1:0]          cmp_hits
);
    import sadm_pkg::*;

    localparam int SYM_W = (SYMBOL_BITS < SYM_FIELD_W) ? SYMBOL_BITS : SYM_FIELD_W;

    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] pat_reg [MAX_PATTERN];

    assign sym = item.symbol_value[SYM_W-1:0];

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_pos
        logic [SYM_W-1:0] diff;

        always_ff @(posedge aclk) begin
            if (load_en && (item.pattern_index == IDX_FIELD_W'(j))) begin
                pat_reg[j] <= sym;
            end
        end

        assign diff        = (sym >= pat_reg[j]) ? (sym - pat_reg[j]) : (pat_reg[j] - sym);
        assign cmp_hits[j] = (DELTA_W'(diff) <= delta);
    end

endmodule

// ----- rtl/core/sadm_match_core.sv -----
// ----------------------------------------------------------------------------
// sadm_match_core
// Match vector and text position update, result formation.
// ----------------------------------------------------------------------------
module sadm_match_core #(
    parameter int  MAX_PATTERN = 64,
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    advance,
    input  sadm_pkg::item_t         item,
    input  logic [MAX_PATTERN-1:0]  cmp_hits,
    input  logic [IDX_W-1:0]        last_idx,
    output sadm_pkg::result_t       result
);
    import sadm_pkg::*;

    logic [MAX_PATTERN-1:0] vec_reg, vec_next;
    logic [MAX_PATTERN-1:0] len_mask;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic                   hit;

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_mask
        assign len_mask[j] = (last_idx >= IDX_W'(j));
    end

    assign hit = vec_next[last_idx];

    always_comb begin
        vec_next = ((vec_reg << 1) | MAX_PATTERN'(1)) & cmp_hits & len_mask;
        pos_next = pos_reg + POS_W'(1);
        result   = '0;
        if (item.req_type == REQ_TEXT && hit) begin
            result.match_found    = 1'b1;
            result.start_position = pos_reg - POS_W'(last_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vec_reg <= '0;
            pos_reg <= '0;
        end else if (advance) begin
            if (item.req_type == REQ_LOAD) begin
                vec_reg <= '0;
                pos_reg <= '0;
            end else begin
                vec_reg <= vec_next;
                pos_reg <= pos_next;
            end
        end
    end

endmodule

// ----- rtl/core/shift_and_delta_match.sv -----
// ----------------------------------------------------------------------------
// shift_and_delta_match
// Shift-and matcher that accepts pattern symbols within a delta tolerance.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled and gives one result
// per item, through an input register, then the parallel compare of the text
// symbol against every pattern position plus the match vector update, then
// the result register. The compare and update are combinational between
// the two registers; a stalled output backs up only through the input register.
// A load item writes one pattern position and restarts matching; its result
// reports no match. Pattern positions read before being loaded are
// unspecified. Registers: index 0 delta threshold, index 1 pattern length.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shift_and_delta_match #(
    parameter int MAX_PATTERN = 64,
    parameter int SYMBOL_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // [5:0] pattern_index, [21:6] symbol_value, [23:22] zero
    input  logic [23:0]                         s_tdata,
    // [0] req_type
    input  logic                                s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [31:0] start_position
    output logic [31:0]                         m_tdata,
    // [0] match_found
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sadm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sadm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sadm_pkg::*;

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam logic [LEN_FIELD_W-1:0] MAX_LEN = LEN_FIELD_W'(MAX_PATTERN);

    logic                   s1_valid_reg;
    item_t                  s1_item_reg;
    logic                   advance;
    logic                   m_valid_reg;
    result_t                m_result_reg;
    result_t                result;
    logic [MAX_PATTERN-1:0] cmp_hits;
    logic [DELTA_W-1:0]     delta_reg;
    logic [IDX_W-1:0]       last_idx_reg, last_idx_next;
    logic [LEN_FIELD_W-1:0] len_wr;
    logic                   cfg_wr;

    // handshake
    assign advance   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || advance;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_result_reg.start_position;
    assign m_tuser   = m_result_reg.match_found;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            s1_item_reg.req_type      <= req_t'(s_tuser);
            s1_item_reg.pattern_index <= s_tdata[IDX_FIELD_W-1:0];
            s1_item_reg.symbol_value  <= s_tdata[IDX_FIELD_W+SYM_FIELD_W-1:IDX_FIELD_W];
        end
        if (advance) begin
            m_result_reg <= result;
        end
    end

    // configuration; the length is kept as its clamped last index
    assign len_wr = cfg_data[LEN_FIELD_W-1:0];

    always_comb begin
        priority if (len_wr == '0) begin
            last_idx_next = '0;
        end else if (len_wr > MAX_LEN) begin
            last_idx_next = IDX_W'(MAX_PATTERN - 1);
        end else begin
            last_idx_next = IDX_W'(len_wr - LEN_FIELD_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delta_reg    <= '0;
            last_idx_reg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_DELTA:  delta_reg    <= cfg_data;
                CFG_LENGTH: last_idx_reg <= last_idx_next;
                default: ;
            endcase
        end
    end

    sadm_pattern_store #(
        .MAX_PATTERN (MAX_PATTERN),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_store (
        .aclk     (aclk),
        .load_en  (advance && s1_item_reg.req_type == REQ_LOAD),
        .item     (s1_item_reg),
        .delta    (delta_reg),
        .cmp_hits (cmp_hits)
    );

    sadm_match_core #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .item     (s1_item_reg),
        .cmp_hits (cmp_hits),
        .last_idx (last_idx_reg),
        .result   (result)
    );

    `ASSERT_NEXT(a_s1_hold, aclk, aresetn, s1_valid_reg && !advance, s1_valid_reg && $stable(s1_item_reg), "input stage lost or changed a stalled item")
    `ASSERT_NEXT(a_adv_out, aclk, aresetn, advance, m_valid_reg, "advanced item produced no result")
    `ASSERT_NEXT(a_load_nomatch, aclk, aresetn, advance && s1_item_reg.req_type == REQ_LOAD, !m_result_reg.match_found && m_result_reg.start_position == '0, "load item reported a match")
    `ASSERT_CLK(a_nomatch_zero, aclk, aresetn, (m_valid_reg && !m_result_reg.match_found) |-> (m_result_reg.start_position == '0), "nonzero start position without match")

endmodule
